// ===== src/lexc_pkg.sv =====
// Package: constants, fixed string table and payload types of the lexeme classifier.
`default_nettype none
package lexc_pkg;

  localparam int unsigned ENTRY_COUNT    = 30;
  localparam int unsigned KEYWORD_COUNT  = 12;
  localparam int unsigned OPERATOR_COUNT = 16;
  localparam int unsigned MAX_LEN        = 6;

  localparam logic [4:0] CLASS_BOOL   = 5'd28;
  localparam logic [4:0] CLASS_NUMBER = 5'd29;
  localparam logic [4:0] CLASS_IDENT  = 5'd30;

  localparam logic [7:0] CHAR_DOT  = 8'h2E;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  // Strings left-justified and padded with spaces; byte p sits at index MAX_LEN-1-p.
  // Padding is never compared, the length gate keeps it out.
  typedef logic [MAX_LEN-1:0][7:0] entry_text_t;

  localparam entry_text_t ENTRY_TEXT [ENTRY_COUNT] = '{
    "if    ", "do    ", "else  ", "elseif", "while ", "return", "func  ",
    "(     ", ")     ", "{     ", "}     ", ",     ",
    "+     ", "-     ", "*     ", "/     ", "%     ", "^     ",
    "<     ", ">     ", "<=    ", ">=    ", "==    ", "!=    ",
    "or    ", "and   ", "not   ", "=     ",
    "true  ", "false "
  };

  localparam logic [2:0] ENTRY_LEN [ENTRY_COUNT] = '{
    3'd2, 3'd2, 3'd4, 3'd6, 3'd5, 3'd6, 3'd4, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
    3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2, 3'd2, 3'd2,
    3'd2, 3'd3, 3'd3, 3'd1,
    3'd4, 3'd5
  };

  localparam logic signed [3:0] OP_PREC [OPERATOR_COUNT] = '{
    4'sd1, 4'sd1, 4'sd2, 4'sd2, 4'sd2, 4'sd3, 4'sd0, 4'sd0,
    4'sd0, 4'sd0, 4'sd0, 4'sd0, -4'sd2, -4'sd1, 4'sd4, 4'sd1
  };

  typedef struct packed {
    logic [7:0] ch;
    logic       has_char;
    logic       last;
  } item_t;

  typedef struct packed {
    logic [4:0]        token_class;
    logic signed [3:0] precedence;
  } result_t;

endpackage
`default_nettype wire

// ===== src/lexc_if.sv =====
// Interfaces: character input channel and token result channel.
`default_nettype none
interface lexc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       has_char;
  logic       last;

  modport source (output valid, output ch, output has_char, output last, input ready);
  modport sink   (input valid, input ch, input has_char, input last, output ready);
endinterface

interface lexc_out_if;
  logic              valid;
  logic              ready;
  logic [4:0]        token_class;
  logic signed [3:0] precedence;

  modport source (output valid, output token_class, output precedence, input ready);
  modport sink   (input valid, input token_class, input precedence, output ready);
endinterface
`default_nettype wire

// ===== src/lexc_scan.sv =====
// Lexeme scan state: per-string match flags, position, number flags and final classification.
`default_nettype none
module lexc_scan (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire lexc_pkg::item_t   item_i,
  output lexc_pkg::result_t      res_o
);
  import lexc_pkg::*;

  logic [ENTRY_COUNT-1:0] match_q, match_d, keep, hit;
  logic [2:0]             pos_q, pos_d, sel;
  logic                   overlong_q, overlong_d;
  logic                   numeric_q, numeric_d;
  logic                   dot_q, dot_d;
  logic                   nonempty_q, nonempty_d;
  logic                   is_digit, found;
  logic [4:0]             first_idx;
  logic [3:0]             op_idx;

  // Byte index of the current position within a padded entry.
  assign sel      = (pos_q < 3'(MAX_LEN)) ? 3'(MAX_LEN - 1) - pos_q : 3'd0;
  assign is_digit = (item_i.ch >= CHAR_ZERO) && (item_i.ch <= CHAR_NINE);

  always_comb begin
    for (int e = 0; e < ENTRY_COUNT; e++) begin
      keep[e] = (pos_q < ENTRY_LEN[e]) && (ENTRY_TEXT[e][sel] == item_i.ch);
    end
  end

  always_comb begin
    match_d    = match_q;
    pos_d      = pos_q;
    overlong_d = overlong_q;
    numeric_d  = numeric_q;
    dot_d      = dot_q;
    nonempty_d = nonempty_q;
    if (item_i.has_char) begin
      match_d    = match_q & keep;
      nonempty_d = 1'b1;
      if (item_i.ch == CHAR_DOT && !dot_q) begin
        dot_d = 1'b1;
      end else if (!is_digit) begin
        numeric_d = 1'b0;
      end
      if (pos_q == 3'd7) begin
        overlong_d = 1'b1;
      end else begin
        pos_d = pos_q + 3'd1;
      end
    end
  end

  // Full-length, still-alive entries; first in table order wins.
  always_comb begin
    found     = 1'b0;
    first_idx = 5'd0;
    for (int e = 0; e < ENTRY_COUNT; e++) begin
      hit[e] = match_d[e] && !overlong_d && (pos_d == ENTRY_LEN[e]);
      if (hit[e] && !found) begin
        found     = 1'b1;
        first_idx = 5'(e);
      end
    end
  end

  assign op_idx = 4'(first_idx - 5'(KEYWORD_COUNT));

  always_comb begin
    res_o.token_class = CLASS_IDENT;
    res_o.precedence  = 4'sd0;
    if (found) begin
      if (first_idx < 5'(KEYWORD_COUNT)) begin
        res_o.token_class = first_idx;
      end else if (first_idx < 5'(KEYWORD_COUNT + OPERATOR_COUNT)) begin
        res_o.token_class = first_idx;
        res_o.precedence  = OP_PREC[op_idx];
      end else begin
        res_o.token_class = CLASS_BOOL;
      end
    end else if (numeric_d && nonempty_d) begin
      res_o.token_class = CLASS_NUMBER;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q    <= '1;
      pos_q      <= '0;
      overlong_q <= 1'b0;
      numeric_q  <= 1'b1;
      dot_q      <= 1'b0;
      nonempty_q <= 1'b0;
    end else if (step_i) begin
      if (item_i.last) begin
        match_q    <= '1;
        pos_q      <= '0;
        overlong_q <= 1'b0;
        numeric_q  <= 1'b1;
        dot_q      <= 1'b0;
        nonempty_q <= 1'b0;
      end else begin
        match_q    <= match_d;
        pos_q      <= pos_d;
        overlong_q <= overlong_d;
        numeric_q  <= numeric_d;
        dot_q      <= dot_d;
        nonempty_q <= nonempty_d;
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/lexeme_token_classifier.sv =====
// Top level: lexeme token classifier with input register, scan logic and result register.
// Usage:
//   in_i carries one lexeme character per transfer (ch, has_char, last). An item
//   with has_char low adds no character, which lets an empty lexeme be closed.
//   out_o carries one token (token_class, precedence) per item marked last; items
//   without last give no transfer on out_o.
// Timing: an item taken on in_i sits in the input register; when it moves on,
//   its token is loaded into the result register and is offered from then on,
//   so out_o.valid is registered and never rises in the cycle of the input transfer.
// Throughput: one item per cycle, unless an item marked last waits on a full
//   result register. The scan state is a handful of flag registers updated by
//   one layer of parallel byte compares, so a character can follow in the very next cycle.
// Stall: while out_o is held off, a token waits in the result register. Items
//   without last keep flowing past it; an item marked last waits in the input
//   register, and in_i.ready drops only when that register cannot move on.
// Reset: rst_ni (async, active low) empties both registers and returns the
//   scan state to the start of a lexeme. State also restarts after each last.
`default_nettype none
module lexeme_token_classifier (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  lexc_in_if.sink     in_i,
  lexc_out_if.source  out_o
);
  import lexc_pkg::*;

  logic    in_valid_q;
  item_t   in_item_q;
  logic    out_valid_q;
  result_t out_res_q;
  result_t scan_res;
  logic    step;
  logic    in_take;

  // The held item moves on unless it would produce a token and the result
  // register is still occupied.
  assign step    = in_valid_q && (!in_item_q.last || !out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || step;
  assign in_take = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q.ch       <= in_i.ch;
      in_item_q.has_char <= in_i.has_char;
      in_item_q.last     <= in_i.last;
    end
  end

  lexc_scan u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_item_q),
    .res_o  (scan_res)
  );

  // Result register: filled by a last item, drained by an output transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && in_item_q.last) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && in_item_q.last) begin
      out_res_q <= scan_res;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.token_class = out_res_q.token_class;
  assign out_o.precedence  = out_res_q.precedence;

endmodule
`default_nettype wire
